>>> hdl/tlbat_pkg.sv
// Shared types and constants of the TLB address translator.
package tlbat_pkg;

    localparam int PAGE_W       = 8;
    localparam int OFFSET_W     = 8;
    localparam int FRAME_W      = 8;
    localparam int VADDR_W      = PAGE_W + OFFSET_W;
    localparam int PADDR_W      = FRAME_W + OFFSET_W;
    localparam int FRAME_CNT_W  = FRAME_W + 1;
    localparam int PAGE_SPAN    = 1 << PAGE_W;
    localparam int DEF_TLB_ENTRIES = 32;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // One classified word from the lookup side to the page-table side.
    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic                hit;
        logic [FRAME_W-1:0]  frame;
    } t_item;

    // TLB refill request from the page-table side back to the lookup side.
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_fill;

endpackage

>>> hdl/tlbat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlbat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tlbat_queue.sv
// Two-entry queue that decouples the TLB lookup from the page-table side.
module tlbat_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tlbat_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output tlbat_pkg::t_item o_item
);
    import tlbat_pkg::*;

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_item  = r_slot[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/tlbat_front.sv
// Fully associative TLB: parallel lookup on accept and FIFO refill.
module tlbat_front #(
    parameter int TLB_ENTRIES = tlbat_pkg::DEF_TLB_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [tlbat_pkg::VADDR_W-1:0] i_virtual_address,
    input  tlbat_pkg::t_tlb_fill          i_fill,
    output logic                          o_push,
    output tlbat_pkg::t_item              o_item
);
    import tlbat_pkg::*;

    localparam int PTR_W = $clog2(TLB_ENTRIES);

    logic [PAGE_W-1:0]      r_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [PTR_W-1:0]       r_ptr;
    logic [PAGE_W-1:0]      w_page;
    logic                   w_hit;
    logic [FRAME_W-1:0]     w_frame;

    assign w_page = i_virtual_address[VADDR_W-1:OFFSET_W];

    // Compare all slots at once; the lowest matching slot wins.
    always_comb begin
        w_hit   = 1'b0;
        w_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == w_page)) begin
                w_hit   = 1'b1;
                w_frame = r_frame[i];
            end
        end
    end

    assign o_push        = i_accept;
    assign o_item.page   = w_page;
    assign o_item.offset = i_virtual_address[OFFSET_W-1:0];
    assign o_item.hit    = w_hit;
    assign o_item.frame  = w_frame;

    always_ff @(posedge i_clk) begin
        if (i_fill.en) begin
            r_tag[r_ptr]   <= i_fill.page;
            r_frame[r_ptr] <= i_fill.frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_fill.en) begin
            r_valid[r_ptr] <= 1'b1;
            r_ptr <= (r_ptr == PTR_W'(TLB_ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(TLB_ENTRIES - 1))
        else $error("TLB insert pointer out of range");

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fill.en |=> r_valid[$past(r_ptr)])
        else $error("refilled TLB slot not marked valid");

endmodule

>>> hdl/tlbat_back.sv
// Page-table side: resolves TLB misses, allocates frames, drives results.
module tlbat_back #(
    parameter int PAGE_COUNT = tlbat_pkg::DEF_PAGE_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tlbat_pkg::t_item              i_q_item,
    output logic                          o_pop,
    output logic                          o_busy,
    output tlbat_pkg::t_tlb_fill          o_fill,
    output logic                          o_valid,
    output logic [tlbat_pkg::PADDR_W-1:0] o_physical_address,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault
);
    import tlbat_pkg::*;

    // Only 256 distinct pages exist, so a larger table has unreachable rows.
    localparam int PT_DEPTH = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
    localparam int PT_AW    = $clog2(PT_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } t_state;

    t_state                 r_state;
    t_item                  r_item;
    logic [PT_AW-1:0]       r_pidx;
    logic [PT_DEPTH-1:0]    r_pt_valid;
    logic [FRAME_CNT_W-1:0] r_nff;
    logic                   r_out_valid;
    logic [PADDR_W-1:0]     r_out_paddr;
    logic                   r_out_hit;
    logic                   r_out_fault;
    logic [PT_AW-1:0]       w_pidx;
    logic [FRAME_W-1:0]     w_pt_rdata;
    logic                   w_fault;
    logic [FRAME_W-1:0]     w_frame;
    logic                   w_pt_we;

    // Page number modulo the table size, as a constant lookup table.
    always_comb begin
        w_pidx = '0;
        for (int p = 0; p < PAGE_SPAN; p++) begin
            if (i_q_item.page == PAGE_W'(p)) begin
                w_pidx = PT_AW'(p % PT_DEPTH);
            end
        end
    end

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_busy  = (r_state != S_IDLE);
    assign w_fault = !r_pt_valid[r_pidx];
    assign w_frame = w_fault ? r_nff[FRAME_W-1:0] : w_pt_rdata;
    assign w_pt_we = (r_state == S_RESOLVE) && w_fault;

    assign o_fill.en    = (r_state == S_RESOLVE);
    assign o_fill.page  = r_item.page;
    assign o_fill.frame = w_frame;

    tlbat_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PT_DEPTH)
    ) u_page_table (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_pidx),
        .i_wdata (r_nff[FRAME_W-1:0]),
        .i_raddr (w_pidx),
        .o_rdata (w_pt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pt_valid  <= '0;
            r_nff       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_pidx <= w_pidx;
                        if (i_q_item.hit) begin
                            r_out_valid <= 1'b1;
                            r_out_paddr <= {i_q_item.frame, i_q_item.offset};
                            r_out_hit   <= 1'b1;
                            r_out_fault <= 1'b0;
                        end else begin
                            r_state <= S_RESOLVE;
                        end
                    end
                end
                S_RESOLVE: begin
                    if (w_fault) begin
                        r_pt_valid[r_pidx] <= 1'b1;
                        if (!r_nff[FRAME_W]) begin
                            r_nff <= r_nff + 1'b1;
                        end
                    end
                    r_out_valid <= 1'b1;
                    r_out_paddr <= {w_frame, r_item.offset};
                    r_out_hit   <= 1'b0;
                    r_out_fault <= w_fault;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_paddr;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;

    a_nff_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nff <= FRAME_CNT_W'(PAGE_SPAN))
        else $error("free frame counter beyond frame limit");

    a_fault_marks_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pt_we |=> r_pt_valid[$past(r_pidx)])
        else $error("faulted page not marked valid");

endmodule

>>> hdl/tlb_fifo_address_translator.sv
// Top level of the TLB address translator with FIFO replacement.
//
// Usage: drive i_virtual_address and raise start; the word is taken at a
// rising edge with start high and busy low. Bits 15..8 are the page and
// bits 7..0 the offset. Each word yields exactly one result: o_valid is
// high for one cycle with o_physical_address = frame*256 + offset,
// o_tlb_hit and o_page_fault. The receiver cannot stall; take the result
// in the cycle it is shown.
// Structure: the lookup side compares the page against every TLB slot in
// parallel on accept and pushes the classified word into a two-entry
// queue. The page-table side pops it; a hit leaves at once, a miss reads
// the page table (synchronous RAM), allocates a frame if the
// page is unmapped and refills the TLB slot under the FIFO pointer.
// Timing: a hit's result is registered by the page-table side as it pops
// the word from the queue; a miss first passes through S_RESOLVE, where
// the page-table RAM read data is used. busy stays high until the TLB
// refill is done, so the next word is taken at the edge that ends the
// result cycle, on hits and misses alike.
// Reset (synchronous, active low) clears TLB and page valid bits, the
// free frame counter and the FIFO pointer; no clearing pass is needed.
module tlb_fifo_address_translator #(
    parameter int TLB_ENTRIES = tlbat_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = tlbat_pkg::DEF_PAGE_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tlbat_pkg::VADDR_W-1:0] i_virtual_address,
    output logic                          o_valid,
    output logic [tlbat_pkg::PADDR_W-1:0] o_physical_address,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault
);
    import tlbat_pkg::*;

    logic      w_accept;
    logic      w_push;
    t_item     w_push_item;
    logic      w_q_valid;
    logic      w_q_full;
    t_item     w_q_item;
    logic      w_pop;
    logic      w_back_busy;
    t_tlb_fill w_fill;

    // Hold off new words while any word is still queued or resolving:
    // the next lookup must see the refill of a preceding miss.
    assign busy     = w_q_valid || w_back_busy;
    assign w_accept = start && !busy;

    tlbat_front #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_virtual_address (i_virtual_address),
        .i_fill            (w_fill),
        .o_push            (w_push),
        .o_item            (w_push_item)
    );

    tlbat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    tlbat_back #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (w_q_valid),
        .i_q_item           (w_q_item),
        .o_pop              (w_pop),
        .o_busy             (w_back_busy),
        .o_fill             (w_fill),
        .o_valid            (o_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("word pushed into a full queue");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("result flags both hit and fault");

    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on consecutive cycles");

    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a word in flight");

endmodule
